// ===== hw/rtl/wsp_pkg.sv =====
// types and constants shared by the wave stencil point update pipeline
package wsp_pkg;

    localparam int VALUE_BITS     = 32;
    localparam int DIFF_BITS      = 35;
    localparam int C2MO_BITS      = 34;
    localparam int COEF_BITS      = 32;
    localparam int COEF_HALF      = 16;
    localparam int COEF_FRAC_BITS = 30;
    localparam int PROD_BITS      = DIFF_BITS + COEF_HALF + 1;
    localparam int SUM_BITS       = PROD_BITS + 2;
    localparam int TOTAL_BITS     = SUM_BITS + COEF_HALF + 1;
    localparam int LAP_BITS       = TOTAL_BITS - COEF_FRAC_BITS;
    localparam int RES_BITS       = LAP_BITS + 1;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 32;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_COEF_X    = 3'd0,
        REG_COEF_Y    = 3'd1,
        REG_COEF_Z    = 3'd2,
        REG_GRID_LAST = 3'd3
    } t_reg_idx;

    typedef struct packed {
        logic [COEF_BITS-1:0] x;
        logic [COEF_BITS-1:0] y;
        logic [COEF_BITS-1:0] z;
    } t_coef;

    typedef struct packed {
        logic signed [DIFF_BITS-1:0]  dxx;
        logic signed [DIFF_BITS-1:0]  dyy;
        logic signed [DIFF_BITS-1:0]  dzz;
        logic signed [C2MO_BITS-1:0]  c2mo;
        logic        [VALUE_BITS-1:0] older;
        logic                         bnd;
    } t_diff;

    typedef struct packed {
        logic signed [SUM_BITS-1:0]   s_hi;
        logic signed [SUM_BITS-1:0]   s_lo;
        logic signed [C2MO_BITS-1:0]  c2mo;
        logic        [VALUE_BITS-1:0] older;
        logic                         bnd;
    } t_sum;

endpackage

// ===== hw/rtl/wave_stencil_point_update_core.sv =====
// top level of the wave stencil point update: config registers and the five-stage pipeline
//
// One leapfrog update of the 3D wave equation per item: new = cx*dxx + cy*dyy + cz*dzz
// + 2*centre - older, rounded to nearest from the Q2.30 coefficient products and saturated
// to 32 bits, with o_m_tuser flagging a clipped result. Points whose row or column index is
// 0 or at least grid_last pass older through. The pipeline has five register stages
// (differences, split-coefficient products, sums, rounding, saturation), and one item is
// taken every cycle while the output is not stalled. Each stage has its own valid bit and
// ready term, so a stalled output still lets items fill empty stages. Configuration writes
// are always taken and must be made while no item is in flight; writes to unknown indexes
// are ignored.
module wave_stencil_point_update_core
    import wsp_pkg::*;
#(
    parameter int INDEX_BITS = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    // centre, x_minus, x_plus, y_minus, y_plus, z_minus, z_plus, older, row_index, col_index
    input  logic [((8 * VALUE_BITS + 2 * INDEX_BITS + 7) / 8) * 8 - 1:0] i_s_tdata,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    // new_value
    output logic [VALUE_BITS-1:0]    o_m_tdata,
    // saturated
    output logic                     o_m_tuser,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int RowLo  = 8 * VALUE_BITS;
    localparam int ColLo  = RowLo + INDEX_BITS;
    localparam logic [INDEX_BITS-1:0] GridLastRst =
        INDEX_BITS'(1023 & ((1 << INDEX_BITS) - 1));

    t_coef                 r_coef;
    logic [INDEX_BITS-1:0] r_grid_last;
    logic                  diff_valid;
    logic                  diff_ready;
    t_diff                 diff_data;
    logic                  sum_valid;
    logic                  sum_ready;
    t_sum                  sum_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef      <= '0;
            r_grid_last <= GridLastRst;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_COEF_X:    r_coef.x    <= i_cfg_data;
                REG_COEF_Y:    r_coef.y    <= i_cfg_data;
                REG_COEF_Z:    r_coef.z    <= i_cfg_data;
                REG_GRID_LAST: r_grid_last <= i_cfg_data[INDEX_BITS-1:0];
                default:       ;
            endcase
        end
    end

    wsp_diff #(
        .INDEX_BITS (INDEX_BITS)
    ) u_diff (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_centre    ($signed(i_s_tdata[0*VALUE_BITS +: VALUE_BITS])),
        .i_x_minus   ($signed(i_s_tdata[1*VALUE_BITS +: VALUE_BITS])),
        .i_x_plus    ($signed(i_s_tdata[2*VALUE_BITS +: VALUE_BITS])),
        .i_y_minus   ($signed(i_s_tdata[3*VALUE_BITS +: VALUE_BITS])),
        .i_y_plus    ($signed(i_s_tdata[4*VALUE_BITS +: VALUE_BITS])),
        .i_z_minus   ($signed(i_s_tdata[5*VALUE_BITS +: VALUE_BITS])),
        .i_z_plus    ($signed(i_s_tdata[6*VALUE_BITS +: VALUE_BITS])),
        .i_older     ($signed(i_s_tdata[7*VALUE_BITS +: VALUE_BITS])),
        .i_row_index (i_s_tdata[RowLo +: INDEX_BITS]),
        .i_col_index (i_s_tdata[ColLo +: INDEX_BITS]),
        .i_grid_last (r_grid_last),
        .o_valid     (diff_valid),
        .i_ready     (diff_ready),
        .o_data      (diff_data)
    );

    wsp_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (diff_valid),
        .o_ready (diff_ready),
        .i_data  (diff_data),
        .i_coef  (r_coef),
        .o_valid (sum_valid),
        .i_ready (sum_ready),
        .o_data  (sum_data)
    );

    wsp_round u_round (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (sum_valid),
        .o_ready     (sum_ready),
        .i_data      (sum_data),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_new_value (o_m_tdata),
        .o_saturated (o_m_tuser)
    );

    // a clipped result sits at one of the two range limits
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |->
            (o_m_tdata == {1'b0, {(VALUE_BITS-1){1'b1}}} ||
             o_m_tdata == {1'b1, {(VALUE_BITS-1){1'b0}}}))
        else $error("saturated flag without a limit value");

    // a free output keeps the whole ready chain open
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tready |-> (o_s_tready && diff_ready && sum_ready))
        else $error("ready chain blocked while output is free");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && !diff_valid && !sum_valid))
        else $error("pipeline not empty after reset");

endmodule

// ===== hw/rtl/wsp_diff.sv =====
// first stage: axis second differences, centre term and boundary detect
module wsp_diff
    import wsp_pkg::*;
#(
    parameter int INDEX_BITS = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [VALUE_BITS-1:0] i_centre,
    input  logic signed [VALUE_BITS-1:0] i_x_minus,
    input  logic signed [VALUE_BITS-1:0] i_x_plus,
    input  logic signed [VALUE_BITS-1:0] i_y_minus,
    input  logic signed [VALUE_BITS-1:0] i_y_plus,
    input  logic signed [VALUE_BITS-1:0] i_z_minus,
    input  logic signed [VALUE_BITS-1:0] i_z_plus,
    input  logic signed [VALUE_BITS-1:0] i_older,
    input  logic        [INDEX_BITS-1:0] i_row_index,
    input  logic        [INDEX_BITS-1:0] i_col_index,
    input  logic        [INDEX_BITS-1:0] i_grid_last,
    output logic                         o_valid,
    input  logic                         i_ready,
    output t_diff                        o_data
);

    logic                        r_vld;
    t_diff                       r_data;
    t_diff                       n_data;
    logic                        en;
    logic signed [DIFF_BITS-1:0] c2;

    assign en      = !r_vld || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld;
    assign o_data  = r_data;

    always_comb begin
        c2           = DIFF_BITS'(i_centre) <<< 1;
        n_data.dxx   = DIFF_BITS'(i_x_minus) + DIFF_BITS'(i_x_plus) - c2;
        n_data.dyy   = DIFF_BITS'(i_y_minus) + DIFF_BITS'(i_y_plus) - c2;
        n_data.dzz   = DIFF_BITS'(i_z_minus) + DIFF_BITS'(i_z_plus) - c2;
        n_data.c2mo  = (C2MO_BITS'(i_centre) <<< 1) - C2MO_BITS'(i_older);
        n_data.older = i_older;
        n_data.bnd   = (i_row_index == '0) || (i_row_index >= i_grid_last)
                    || (i_col_index == '0) || (i_col_index >= i_grid_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== hw/rtl/wsp_mac.sv =====
// second and third stages: split-coefficient products and their sums
module wsp_mac
    import wsp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_diff i_data,
    input  t_coef i_coef,
    output logic  o_valid,
    input  logic  i_ready,
    output t_sum  o_data
);

    logic                         r_vld1;
    logic                         r_vld2;
    logic                         en1;
    logic                         en2;
    logic signed [PROD_BITS-1:0]  r_prod [6];
    logic signed [PROD_BITS-1:0]  n_prod [6];
    logic signed [C2MO_BITS-1:0]  r_c2mo;
    logic        [VALUE_BITS-1:0] r_older;
    logic                         r_bnd;
    t_sum                         r_sum;
    t_sum                         n_sum;

    assign en2     = !r_vld2 || i_ready;
    assign en1     = !r_vld1 || en2;
    assign o_ready = en1;
    assign o_valid = r_vld2;
    assign o_data  = r_sum;

    // high halves in slots 0..2, low halves in slots 3..5
    always_comb begin
        n_prod[0] = PROD_BITS'(i_data.dxx)
                  * PROD_BITS'($signed({1'b0, i_coef.x[COEF_BITS-1:COEF_HALF]}));
        n_prod[1] = PROD_BITS'(i_data.dyy)
                  * PROD_BITS'($signed({1'b0, i_coef.y[COEF_BITS-1:COEF_HALF]}));
        n_prod[2] = PROD_BITS'(i_data.dzz)
                  * PROD_BITS'($signed({1'b0, i_coef.z[COEF_BITS-1:COEF_HALF]}));
        n_prod[3] = PROD_BITS'(i_data.dxx)
                  * PROD_BITS'($signed({1'b0, i_coef.x[COEF_HALF-1:0]}));
        n_prod[4] = PROD_BITS'(i_data.dyy)
                  * PROD_BITS'($signed({1'b0, i_coef.y[COEF_HALF-1:0]}));
        n_prod[5] = PROD_BITS'(i_data.dzz)
                  * PROD_BITS'($signed({1'b0, i_coef.z[COEF_HALF-1:0]}));
    end

    always_comb begin
        n_sum.s_hi  = SUM_BITS'(r_prod[0]) + SUM_BITS'(r_prod[1]) + SUM_BITS'(r_prod[2]);
        n_sum.s_lo  = SUM_BITS'(r_prod[3]) + SUM_BITS'(r_prod[4]) + SUM_BITS'(r_prod[5]);
        n_sum.c2mo  = r_c2mo;
        n_sum.older = r_older;
        n_sum.bnd   = r_bnd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (en1) begin
                r_vld1 <= i_valid;
            end
            if (en2) begin
                r_vld2 <= r_vld1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_prod  <= n_prod;
            r_c2mo  <= i_data.c2mo;
            r_older <= i_data.older;
            r_bnd   <= i_data.bnd;
        end
        if (en2 && r_vld1) begin
            r_sum <= n_sum;
        end
    end

endmodule

// ===== hw/rtl/wsp_round.sv =====
// fourth and fifth stages: rounding to the value format, centre term, saturation
module wsp_round
    import wsp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_sum                  i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [VALUE_BITS-1:0] o_new_value,
    output logic                  o_saturated
);

    localparam logic signed [TOTAL_BITS-1:0] RoundHalf =
        TOTAL_BITS'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [RES_BITS-1:0] ResMax = RES_BITS'((64'sd1 <<< (VALUE_BITS - 1)) - 1);
    localparam logic signed [RES_BITS-1:0] ResMin = -RES_BITS'(64'sd1 <<< (VALUE_BITS - 1));

    logic                         r_vld1;
    logic                         r_vld2;
    logic                         en1;
    logic                         en2;
    logic signed [TOTAL_BITS-1:0] total;
    logic signed [LAP_BITS-1:0]   r_lap;
    logic signed [C2MO_BITS-1:0]  r_c2mo;
    logic        [VALUE_BITS-1:0] r_older;
    logic                         r_bnd;
    logic signed [RES_BITS-1:0]   res;
    logic        [VALUE_BITS-1:0] r_value;
    logic        [VALUE_BITS-1:0] n_value;
    logic                         r_sat;
    logic                         n_sat;

    assign en2         = !r_vld2 || i_ready;
    assign en1         = !r_vld1 || en2;
    assign o_ready     = en1;
    assign o_valid     = r_vld2;
    assign o_new_value = r_value;
    assign o_saturated = r_sat;

    assign total = {i_data.s_hi[SUM_BITS-1], i_data.s_hi, {COEF_HALF{1'b0}}}
                 + TOTAL_BITS'(i_data.s_lo) + RoundHalf;

    always_comb begin
        res = RES_BITS'(r_lap) + RES_BITS'(r_c2mo);
        if (r_bnd) begin
            n_value = r_older;
            n_sat   = 1'b0;
        end else if (res > ResMax) begin
            n_value = ResMax[VALUE_BITS-1:0];
            n_sat   = 1'b1;
        end else if (res < ResMin) begin
            n_value = ResMin[VALUE_BITS-1:0];
            n_sat   = 1'b1;
        end else begin
            n_value = res[VALUE_BITS-1:0];
            n_sat   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (en1) begin
                r_vld1 <= i_valid;
            end
            if (en2) begin
                r_vld2 <= r_vld1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_lap   <= total[TOTAL_BITS-1:COEF_FRAC_BITS];
            r_c2mo  <= i_data.c2mo;
            r_older <= i_data.older;
            r_bnd   <= i_data.bnd;
        end
        if (en2 && r_vld1) begin
            r_value <= n_value;
            r_sat   <= n_sat;
        end
    end

endmodule
